// ----- sv/assert_macros.svh -----
// Assertion macros used by the verification checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- sv/pidfd_pkg.sv -----
// Types and constants for the PID controller with filtered derivative.
`default_nettype none

package pidfd_pkg;

  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int DT_W     = 16;
  localparam int ACC_W    = 48;
  localparam int CHUNK_W  = 24;
  localparam int MAC_W    = 96;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_GAIN_PROP  = 3'd0;
  localparam cfg_idx_t REG_GAIN_INTEG = 3'd1;
  localparam cfg_idx_t REG_GAIN_DERIV = 3'd2;
  localparam cfg_idx_t REG_LIMIT_HIGH = 3'd3;
  localparam cfg_idx_t REG_LIMIT_LOW  = 3'd4;

  localparam logic [DT_W-1:0] DT_MIN_RAW = 16'd7;
  localparam logic signed [DATA_W-1:0] COEF_NEW = 32'sd45875;
  localparam logic signed [DATA_W-1:0] COEF_OLD = 32'sd19661;

  typedef struct packed {
    logic signed [DATA_W-1:0] error_sample;
    logic [DT_W-1:0]          time_step;
  } in_payload_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_value;
    logic                     was_clamped;
  } out_payload_t;

endpackage

`default_nettype wire

// ----- sv/pid_filtered_derivative_unit.sv -----
// A sample is taken only in S_IDLE; in_stall stays high until its result is loaded
// into the output register, so one sample is done before the next is taken. A
// bit-serial divider and a single shared 32x25 multiplier do the math; the divider
// is skipped when the derivative is forced to zero (first sample or time step below
// 7 LSB). Reset: synchronous active-low rst_n clears gains, sets the limits to full
// range, clears the I and D accumulators and arms the first-sample flag.
`default_nettype none

module pid_filtered_derivative_unit (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire pidfd_pkg::in_payload_t in_payload,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output pidfd_pkg::out_payload_t     out_payload,
  input  wire logic                   cfg_wr_en,
  input  wire pidfd_pkg::cfg_idx_t    cfg_index,
  input  wire logic [31:0]            cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DIV      = 7'b0000010,
    S_MAC      = 7'b0000100,
    S_DRAIN    = 7'b0001000,
    S_POST     = 7'b0010000,
    S_CLAMP_LO = 7'b0100000,
    S_CLAMP_HI = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    PH_DERIV = 3'b001,
    PH_INTEG = 3'b010,
    PH_OUT   = 3'b100
  } phase_t;

  localparam logic [5:0] DIV_LAST = 6'd47;
  localparam logic signed [95:0] MAC_HALF = 96'sd32768;
  localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

  function automatic logic signed [47:0] sat_acc(input logic signed [79:0] v);
    logic signed [47:0] r;
    if (v[79:47] == {33{v[79]}}) begin
      r = v[47:0];
    end else begin
      r = v[79] ? ACC_MIN : ACC_MAX;
    end
    return r;
  endfunction

  state_t state_r, state_nxt;
  phase_t phase_r;
  logic [5:0] cnt_r;
  logic first_r;
  logic prod_vld_r;
  logic out_valid_r;
  pidfd_pkg::out_payload_t out_payload_r;

  logic signed [31:0] gain_prop_r, gain_integ_r, gain_deriv_r, limit_high_r, limit_low_r;
  logic signed [31:0] prev_r, e_r;
  logic signed [47:0] iacc_r, dacc_r, q_r;
  logic [15:0] dt_r, rem_r;
  logic [47:0] num_r;
  logic neg_r;
  logic signed [95:0] prod_r, acc_r;
  logic signed [79:0] x_r, y_r;
  logic lo_hit_r;

  logic signed [32:0] diff;
  logic [32:0] diff_neg;
  logic [31:0] diff_mag;
  logic deriv_skip;
  logic [17:0] trial;
  logic fits;
  logic [15:0] rem_nxt;
  logic [47:0] num_nxt;
  logic signed [31:0] op_a;
  logic signed [47:0] op_b;
  logic half;
  logic signed [24:0] b_part;
  logic signed [56:0] mul_res;
  logic signed [95:0] prod_ext, prod_nxt;
  logic [2:0] mac_last;
  logic acc_init;
  logic signed [79:0] acc_q, isum, lo_ext, hi_ext;
  logic lo_hit, hi_hit, out_free;

  assign diff       = {in_payload.error_sample[31], in_payload.error_sample}
                    - {prev_r[31], prev_r};
  assign diff_neg   = -diff;
  assign diff_mag   = diff[32] ? diff_neg[31:0] : diff[31:0];
  assign deriv_skip = first_r || (in_payload.time_step < pidfd_pkg::DT_MIN_RAW);

  assign trial   = {1'b0, rem_r, num_r[47]} - {2'b00, dt_r};
  assign fits    = !trial[17];
  assign rem_nxt = fits ? trial[15:0] : {rem_r[14:0], num_r[47]};
  assign num_nxt = {num_r[46:0], fits};

  always_comb begin
    op_a = gain_integ_r;
    op_b = iacc_r;
    case (phase_r)
      PH_DERIV: begin
        op_a = cnt_r[1] ? pidfd_pkg::COEF_OLD : pidfd_pkg::COEF_NEW;
        op_b = cnt_r[1] ? dacc_r : q_r;
      end
      PH_INTEG: begin
        op_a = e_r;
        op_b = {32'b0, dt_r};
      end
      PH_OUT: begin
        case (cnt_r[2:1])
          2'd0: begin
            op_a = gain_prop_r;
            op_b = {{16{e_r[31]}}, e_r};
          end
          2'd1: begin
            op_a = gain_deriv_r;
            op_b = dacc_r;
          end
          default: begin
            op_a = gain_integ_r;
            op_b = iacc_r;
          end
        endcase
      end
      default: begin
        op_a = gain_integ_r;
        op_b = iacc_r;
      end
    endcase
  end

  assign half     = cnt_r[0];
  assign b_part   = half ? {op_b[47], op_b[47:pidfd_pkg::CHUNK_W]}
                         : {1'b0, op_b[pidfd_pkg::CHUNK_W-1:0]};
  assign mul_res  = 57'(op_a) * 57'(b_part);
  assign prod_ext = 96'(mul_res);
  assign prod_nxt = half ? (prod_ext <<< pidfd_pkg::CHUNK_W) : prod_ext;

  always_comb begin
    case (phase_r)
      PH_DERIV: mac_last = 3'd3;
      PH_INTEG: mac_last = 3'd1;
      PH_OUT:   mac_last = 3'd5;
      default:  mac_last = 3'd5;
    endcase
  end

  assign acc_q    = acc_r[95:16];
  assign isum     = {{32{iacc_r[47]}}, iacc_r} + {{47{acc_r[48]}}, acc_r[48:16]};
  assign lo_ext   = {{48{limit_low_r[31]}}, limit_low_r};
  assign hi_ext   = {{48{limit_high_r[31]}}, limit_high_r};
  assign lo_hit   = x_r < lo_ext;
  assign hi_hit   = hi_ext < y_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = deriv_skip ? S_MAC : S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (cnt_r[2:0] == mac_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:    state_nxt = S_POST;
      S_POST:     state_nxt = (phase_r == PH_OUT) ? S_CLAMP_LO : S_MAC;
      S_CLAMP_LO: state_nxt = S_CLAMP_HI;
      S_CLAMP_HI: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  assign acc_init = (state_nxt == S_MAC) && (state_r != S_MAC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_INTEG;
      cnt_r        <= '0;
      first_r      <= 1'b1;
      prod_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_r       <= '0;
      iacc_r       <= '0;
      dacc_r       <= '0;
      gain_prop_r  <= '0;
      gain_integ_r <= '0;
      gain_deriv_r <= '0;
      limit_high_r <= 32'sh7FFFFFFF;
      limit_low_r  <= 32'sh80000000;
    end else begin
      state_r    <= state_nxt;
      prod_vld_r <= (state_r == S_MAC);
      if (state_r != state_nxt) begin
        cnt_r <= '0;
      end else if (state_r == S_DIV || state_r == S_MAC) begin
        cnt_r <= cnt_r + 6'd1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            prev_r  <= in_payload.error_sample;
            first_r <= 1'b0;
            if (deriv_skip) begin
              dacc_r  <= '0;
              phase_r <= PH_INTEG;
            end else begin
              phase_r <= PH_DERIV;
            end
          end
        end
        S_POST: begin
          case (phase_r)
            PH_DERIV: begin
              dacc_r  <= sat_acc(acc_q);
              phase_r <= PH_INTEG;
            end
            PH_INTEG: begin
              iacc_r  <= sat_acc(isum);
              phase_r <= PH_OUT;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (state_r == S_CLAMP_HI && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          pidfd_pkg::REG_GAIN_PROP: begin
            gain_prop_r <= cfg_wdata;
            first_r     <= 1'b1;
          end
          pidfd_pkg::REG_GAIN_INTEG: begin
            gain_integ_r <= cfg_wdata;
            first_r      <= 1'b1;
          end
          pidfd_pkg::REG_GAIN_DERIV: begin
            gain_deriv_r <= cfg_wdata;
            first_r      <= 1'b1;
          end
          pidfd_pkg::REG_LIMIT_HIGH: begin
            limit_high_r <= cfg_wdata;
            first_r      <= 1'b1;
          end
          pidfd_pkg::REG_LIMIT_LOW: begin
            limit_low_r <= cfg_wdata;
            first_r     <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (prod_vld_r) begin
      acc_r <= (phase_r == PH_OUT) ? (acc_r - prod_r) : (acc_r + prod_r);
    end
    if (acc_init) begin
      acc_r <= MAC_HALF;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          e_r   <= in_payload.error_sample;
          dt_r  <= in_payload.time_step;
          neg_r <= diff[32];
          num_r <= {diff_mag, 16'b0};
          rem_r <= '0;
        end
      end
      S_DIV: begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        if (cnt_r == DIV_LAST) begin
          q_r <= neg_r ? -num_nxt : num_nxt;
        end
      end
      S_POST: x_r <= acc_q;
      S_CLAMP_LO: begin
        y_r      <= lo_hit ? lo_ext : x_r;
        lo_hit_r <= lo_hit;
      end
      S_CLAMP_HI: begin
        if (out_free) begin
          out_payload_r.drive_value <= hi_hit ? limit_high_r : y_r[31:0];
          out_payload_r.was_clamped <= hi_hit ? (hi_ext != x_r) : lo_hit_r;
        end
      end
      default: ;
    endcase
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

endmodule

`default_nettype wire

// ----- sv/pidfd_checker.sv -----
// Port-level checker for the PID unit, attached to pid_filtered_derivative_unit by bind.
`default_nettype none
`include "assert_macros.svh"

module pidfd_checker (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire pidfd_pkg::in_payload_t  in_payload,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire pidfd_pkg::out_payload_t out_payload
);

  logic [1:0] pend_r;
  logic in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Count transactions taken in whose results have not yet been delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall)
  `ASSERT_IMPL(a_ready_with_result, clk, rst_n, $rose(out_valid), !in_stall)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))
  `ASSERT_IMPL(a_no_phantom, clk, rst_n, out_valid, pend_r != 2'd0)
  `ASSERT_IMPL(a_accept_room, clk, rst_n, in_acc, pend_r != 2'd2)

endmodule

bind pid_filtered_derivative_unit pidfd_checker u_pidfd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_payload  (in_payload),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_payload (out_payload)
);

`default_nettype wire

// ----- sim/tb_pid_filtered_derivative_unit.sv -----
// Self-checking testbench for the PID controller with filtered derivative.
`timescale 1ns / 1ps

module tb_pid_filtered_derivative_unit;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 80;
  localparam int MAX_REPORTS = 10;

  class drive_scoreboard;
    longint gain_p, gain_i, gain_d, lim_hi, lim_lo;
    longint prev_err, integ, deriv;
    bit first;
    pidfd_pkg::out_payload_t expected_drive[$];
    int errors;

    function new();
      gain_p = 0;
      gain_i = 0;
      gain_d = 0;
      lim_hi = 64'sd2147483647;
      lim_lo = -64'sd2147483648;
      prev_err = 0;
      integ = 0;
      deriv = 0;
      first = 1'b1;
      errors = 0;
    endfunction

    function longint acc_sat(logic signed [127:0] v);
      longint top;
      top = (longint'(1) <<< (pidfd_pkg::ACC_W - 1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v[63:0];
    endfunction

    function void write_reg(pidfd_pkg::cfg_idx_t idx, logic [31:0] val);
      longint v;
      v = $signed(val);
      case (idx)
        pidfd_pkg::REG_GAIN_PROP: gain_p = v;
        pidfd_pkg::REG_GAIN_INTEG: gain_i = v;
        pidfd_pkg::REG_GAIN_DERIV: gain_d = v;
        pidfd_pkg::REG_LIMIT_HIGH: lim_hi = v;
        pidfd_pkg::REG_LIMIT_LOW: lim_lo = v;
        default: return;
      endcase
      first = 1'b1;
    endfunction

    function void note_sample(pidfd_pkg::in_payload_t smp);
      logic signed [127:0] e, dt, q, x, y;
      pidfd_pkg::out_payload_t drive;
      e = $signed(smp.error_sample);
      dt = $signed({1'b0, smp.time_step});
      if (first) begin
        deriv = 0;
        first = 1'b0;
      end else if (smp.time_step < pidfd_pkg::DT_MIN_RAW) begin
        deriv = 0;
      end else begin
        q = ((e - prev_err) <<< pidfd_pkg::DT_W) / dt;
        deriv = acc_sat((q * pidfd_pkg::COEF_NEW + deriv * pidfd_pkg::COEF_OLD
                         + (1 <<< (pidfd_pkg::DT_W - 1))) >>> pidfd_pkg::DT_W);
      end
      integ = acc_sat(integ + ((e * dt + (1 <<< (pidfd_pkg::DT_W - 1)))
                               >>> pidfd_pkg::DT_W));
      prev_err = e[63:0];
      x = gain_p * e + gain_d * deriv + gain_i * integ;
      x = (-x + (1 <<< (pidfd_pkg::FRAC_W - 1))) >>> pidfd_pkg::FRAC_W;
      y = x;
      if (y < lim_lo) y = lim_lo;
      if (y > lim_hi) y = lim_hi;
      drive.drive_value = y[pidfd_pkg::DATA_W-1:0];
      drive.was_clamped = (y != x);
      expected_drive.push_back(drive);
    endfunction

    function void check_drive(pidfd_pkg::out_payload_t got);
      pidfd_pkg::out_payload_t want;
      if (expected_drive.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected transaction: drive %0d clamp %0b", got.drive_value,
                   got.was_clamped);
        return;
      end
      want = expected_drive.pop_front();
      if (got.drive_value !== want.drive_value || got.was_clamped !== want.was_clamped) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: expected drive %0d clamp %0b, got drive %0d clamp %0b",
                   want.drive_value, want.was_clamped, got.drive_value, got.was_clamped);
      end
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pidfd_pkg::in_payload_t in_payload = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pidfd_pkg::out_payload_t out_payload;
  logic cfg_wr_en = 1'b0;
  pidfd_pkg::cfg_idx_t cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  drive_scoreboard sb;
  int send_idle = 0;
  int stall_pct = 0;
  int cycles = 0;
  int idle_send[4] = '{0, 57, 0, 31};
  int idle_recv[4] = '{0, 0, 57, 31};

  pid_filtered_derivative_unit i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_payload(out_payload),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_drive(out_payload);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic pidfd_pkg::in_payload_t sample(logic [31:0] e, logic [15:0] dt);
    pidfd_pkg::in_payload_t p;
    p.error_sample = e;
    p.time_step = dt;
    return p;
  endfunction

  function automatic logic [31:0] moderate(int span_log2);
    return $urandom_range(0, 1 << span_log2) - (1 << (span_log2 - 1));
  endfunction

  function automatic logic [31:0] extreme();
    return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  function automatic logic [31:0] rand_error();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return moderate(20);
      6: return $urandom();
      7: return extreme();
      8: return $urandom_range(0, 255) - 128;
      default: return '0;
    endcase
  endfunction

  function automatic logic [15:0] rand_step();
    case ($urandom_range(9))
      0: return 16'($urandom_range(0, pidfd_pkg::DT_MIN_RAW - 1));
      1: return $urandom_range(1) ? 16'hFFFF : pidfd_pkg::DT_MIN_RAW;
      2: return 16'($urandom_range(0, 16'hFFFF));
      default: return 16'($urandom_range(pidfd_pkg::DT_MIN_RAW, 4000));
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(3))
      0: return $urandom();
      1: return extreme();
      default: return moderate(19);
    endcase
  endfunction

  task automatic write_reg(pidfd_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                              logic [31:0] hi, logic [31:0] lo);
    write_reg(pidfd_pkg::REG_GAIN_PROP, gp);
    write_reg(pidfd_pkg::REG_GAIN_INTEG, gi);
    write_reg(pidfd_pkg::REG_GAIN_DERIV, gd);
    write_reg(pidfd_pkg::REG_LIMIT_HIGH, hi);
    write_reg(pidfd_pkg::REG_LIMIT_LOW, lo);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_sample(pidfd_pkg::in_payload_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(p);
  endtask

  initial begin
    logic [31:0] lim_a, lim_b;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0064_0000, 32'hFF9C_0000);
    send_sample(sample(32'h0001_0000, 16'd655));
    send_sample(sample(32'h0002_0000, 16'd655));
    send_sample(sample(32'h7FFF_FFFF, 16'hFFFF));
    send_sample(sample(32'h8000_0000, pidfd_pkg::DT_MIN_RAW));
    send_sample(sample(32'h0000_0000, pidfd_pkg::DT_MIN_RAW - 16'd1));
    send_sample(sample(32'hFFFF_0000, 16'd0));
    send_sample(sample(32'h0001_0000, 16'd1));
    send_sample(sample(32'h0003_0000, 16'd100));
    drain();
    for (int k = pidfd_pkg::REG_LIMIT_LOW + 1; k < (1 << pidfd_pkg::CFG_IDX_W); k++)
      write_reg(pidfd_pkg::cfg_idx_t'(k), $urandom());
    cfg_wr_en <= 1'b0;
    send_sample(sample(32'hFFFE_0000, 16'd100));
    drain();
    write_reg(pidfd_pkg::REG_LIMIT_HIGH, 32'h0064_0000);
    cfg_wr_en <= 1'b0;
    send_sample(sample(32'h0005_0000, 16'd100));
    send_sample(sample(32'h0004_0000, pidfd_pkg::DT_MIN_RAW - 16'd1));
    send_sample(sample(32'h0004_8000, 16'd1000));
    drain();
    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(sample(32'h7FFF_FFFF, 16'hFFFF));
    send_sample(sample(32'h8000_0000, pidfd_pkg::DT_MIN_RAW));
    send_sample(sample(32'hFFFF_FFFF, 16'hFFFF));
    send_sample(sample(32'h0000_0001, 16'h8000));

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      lim_a = $urandom_range(1 << 20, 1 << 26);
      lim_b = moderate(26);
      case (ph)
        0: program_regs(moderate(19), moderate(19), moderate(19), lim_a, -lim_a);
        1: program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000);
        2: program_regs(moderate(19), moderate(19), moderate(19),
                        32'h7FFF_FFFF, 32'h8000_0000);
        3: program_regs(moderate(19), moderate(19), moderate(19), -lim_a, lim_a);
        4: program_regs(32'h0, 32'h0, moderate(19), lim_b, lim_b);
        default: program_regs(rand_gain(), rand_gain(), rand_gain(), moderate(26), lim_b);
      endcase
      send_idle = idle_send[ph % 4];
      stall_pct = idle_recv[ph % 4];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(39) == 0) drain();
        send_sample(sample(rand_error(), rand_step()));
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/pidfd_pkg.sv
sv/pid_filtered_derivative_unit.sv
sv/pidfd_checker.sv
sim/tb_pid_filtered_derivative_unit.sv
